FILE: src/assert_macros.svh
// Assertion macros for the scheduler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scheduler assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scheduler assertion failed");

`endif

FILE: src/ptrs_pkg.sv
// Package with constants, codes and types of the periodic task release scheduler.
`timescale 1ns / 1ps

package ptrs_pkg;

    localparam int TASK_SLOTS_DEF = 8;
    localparam int MAX_RESULTS = 8;
    localparam int KICK_W = 16;
    localparam logic [KICK_W-1:0] KICK_PERIOD_RST = 16'd100;
    localparam int TIME_W = 32;
    localparam int FUNC_W = 3;
    localparam int SLOT_W = 3;

    typedef enum logic [FUNC_W-1:0] {
        FN_TICK     = 3'd0,
        FN_REGISTER = 3'd1,
        FN_ENABLE   = 3'd2,
        FN_DISABLE  = 3'd3,
        FN_CLEAR    = 3'd4
    } func_t;

    typedef struct packed {
        logic              load;
        logic              en_set;
        logic              en_clr;
        logic              clr_all;
        logic [TIME_W-1:0] now;
        logic [TIME_W-1:0] period;
    } cell_cmd_t;

endpackage

FILE: src/periodic_task_release_scheduler.sv
// Top level of the periodic task release scheduler: command decode, scan control, results.
//
// Usage: drive func, now_ms, period_ms and slot with start high; the word is
// taken at a rising edge where start is high and busy is low. Results come
// one per cycle on released, task_index, kicked, accepted and final_res,
// each marked by done for exactly one cycle; final_res flags the last
// result of a command. The receiver cannot hold results off.
// Register, enable, disable, clear and unknown commands give one result in
// the cycle after acceptance and leave busy low, so one command per cycle.
// A tick passes a token down the chain of TASK_SLOTS task cells, one cell
// per cycle, then gives the closing result from the flush state; busy stays
// high through the scan and the flush, so the next word waits until both
// are done. Released tasks are reported in index order; each one is held
// until the token finds the next release and shows in the cycle after that,
// and the last comes after the scan with final_res.
// kick_period is written through cfg_we and cfg_wdata; the user must do so only
// while idle, as the block itself does not enforce it. Reset empties the task table,
// zeroes the last kick time and sets kick_period to 100.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module periodic_task_release_scheduler #(
    parameter int TASK_SLOTS = ptrs_pkg::TASK_SLOTS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [ptrs_pkg::FUNC_W-1:0]    func,
    input  logic [ptrs_pkg::TIME_W-1:0]    now_ms,
    input  logic [ptrs_pkg::TIME_W-1:0]    period_ms,
    input  logic [ptrs_pkg::SLOT_W-1:0]    slot,
    input  logic                           cfg_we,
    input  logic [ptrs_pkg::KICK_W-1:0]    cfg_wdata,
    output logic                           done,
    output logic                           released,
    output logic [ptrs_pkg::SLOT_W-1:0]    task_index,
    output logic                           kicked,
    output logic                           accepted,
    output logic                           final_res
);

    localparam int IDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int CNT_W = $clog2(TASK_SLOTS + 1);
    localparam int CMP_W = (CNT_W > ptrs_pkg::SLOT_W) ? CNT_W : ptrs_pkg::SLOT_W;
    localparam int RCNT_W = $clog2(ptrs_pkg::MAX_RESULTS + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TASK_SLOTS - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TASK_SLOTS);
    localparam logic [RCNT_W-1:0] MAX_CNT = RCNT_W'(ptrs_pkg::MAX_RESULTS);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_FLUSH = 3'b100
    } state_t;

    state_t                        state_reg, state_next;
    logic [CNT_W-1:0]              total_reg, total_next;
    logic [ptrs_pkg::TIME_W-1:0]   last_kick_reg, last_kick_next;
    logic [ptrs_pkg::KICK_W-1:0]   kick_period_reg;
    logic [ptrs_pkg::TIME_W-1:0]   now_reg, now_next;
    logic [IDX_W-1:0]              scan_idx_reg, scan_idx_next;
    logic [RCNT_W-1:0]             rcnt_reg, rcnt_next;
    logic                          pend_valid_reg, pend_valid_next;
    logic [ptrs_pkg::SLOT_W-1:0]   pend_idx_reg, pend_idx_next;
    logic                          any_hit_reg, any_hit_next;

    logic                          done_reg, done_next;
    logic                          released_reg, released_next;
    logic [ptrs_pkg::SLOT_W-1:0]   task_index_reg, task_index_next;
    logic                          kicked_reg, kicked_next;
    logic                          accepted_reg, accepted_next;
    logic                          final_res_reg, final_res_next;

    ptrs_pkg::cell_cmd_t           cmd;
    logic [CMP_W-1:0]              sel_idx;
    logic [CMP_W-1:0]              total_ext;
    logic [CMP_W-1:0]              slot_ext;
    logic [CMP_W-1:0]              scan_ext;
    logic                          take;
    logic                          tick_start;
    logic                          timeout;
    logic                          kick_now;
    logic                          hit_any;
    logic [TASK_SLOTS-1:0]         sel_vec;
    logic [TASK_SLOTS-1:0]         tok_vec;
    logic [TASK_SLOTS-1:0]         hit_vec;

    assign busy      = (state_reg != ST_IDLE);
    assign take      = start && !busy;
    assign total_ext = CMP_W'(total_reg);
    assign slot_ext  = CMP_W'(slot);
    assign scan_ext  = CMP_W'(scan_idx_reg);
    assign hit_any   = |hit_vec;
    assign timeout   = (now_reg - last_kick_reg) > ptrs_pkg::TIME_W'(kick_period_reg);
    assign kick_now  = any_hit_reg || timeout;

    genvar g;
    generate
        for (g = 0; g < TASK_SLOTS; g++)
        begin : g_cell
            assign sel_vec[g] = (sel_idx == CMP_W'(g));
            if (g == 0)
            begin : g_head
                ptrs_cell u_cell (
                    .clk     (clk),
                    .rst_n   (rst_n),
                    .cmd     (cmd),
                    .sel     (sel_vec[g]),
                    .tok_in  (tick_start),
                    .tok_out (tok_vec[g]),
                    .hit     (hit_vec[g])
                );
            end
            else
            begin : g_body
                ptrs_cell u_cell (
                    .clk     (clk),
                    .rst_n   (rst_n),
                    .cmd     (cmd),
                    .sel     (sel_vec[g]),
                    .tok_in  (tok_vec[g-1]),
                    .tok_out (tok_vec[g]),
                    .hit     (hit_vec[g])
                );
            end
        end
    endgenerate

    always_comb
    begin
        state_next      = state_reg;
        total_next      = total_reg;
        last_kick_next  = last_kick_reg;
        now_next        = now_reg;
        scan_idx_next   = scan_idx_reg;
        rcnt_next       = rcnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        any_hit_next    = any_hit_reg;
        done_next       = 1'b0;
        released_next   = 1'b0;
        task_index_next = '0;
        kicked_next     = 1'b0;
        accepted_next   = 1'b0;
        final_res_next  = 1'b0;
        cmd.load        = 1'b0;
        cmd.en_set      = 1'b0;
        cmd.en_clr      = 1'b0;
        cmd.clr_all     = 1'b0;
        cmd.now         = now_reg;
        cmd.period      = period_ms;
        sel_idx         = slot_ext;
        tick_start      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    case (ptrs_pkg::func_t'(func))
                        ptrs_pkg::FN_TICK:
                        begin
                            tick_start      = 1'b1;
                            now_next        = now_ms;
                            scan_idx_next   = '0;
                            rcnt_next       = '0;
                            pend_valid_next = 1'b0;
                            any_hit_next    = 1'b0;
                            state_next      = ST_SCAN;
                        end
                        ptrs_pkg::FN_REGISTER:
                        begin
                            done_next      = 1'b1;
                            final_res_next = 1'b1;
                            if (total_reg < FULL_CNT)
                            begin
                                sel_idx         = total_ext;
                                cmd.load        = 1'b1;
                                total_next      = total_reg + CNT_W'(1);
                                accepted_next   = 1'b1;
                                task_index_next = total_ext[ptrs_pkg::SLOT_W-1:0];
                            end
                        end
                        ptrs_pkg::FN_ENABLE, ptrs_pkg::FN_DISABLE:
                        begin
                            done_next       = 1'b1;
                            final_res_next  = 1'b1;
                            accepted_next   = 1'b1;
                            task_index_next = slot;
                            if (slot_ext < total_ext)
                            begin
                                cmd.en_set = (func == ptrs_pkg::FN_ENABLE);
                                cmd.en_clr = (func == ptrs_pkg::FN_DISABLE);
                            end
                        end
                        ptrs_pkg::FN_CLEAR:
                        begin
                            done_next      = 1'b1;
                            final_res_next = 1'b1;
                            accepted_next  = 1'b1;
                            cmd.clr_all    = 1'b1;
                            total_next     = '0;
                            last_kick_next = now_ms;
                        end
                        default:
                        begin
                            done_next      = 1'b1;
                            final_res_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (hit_any)
                begin
                    any_hit_next = 1'b1;
                    if (rcnt_reg < MAX_CNT)
                    begin
                        if (pend_valid_reg)
                        begin
                            done_next       = 1'b1;
                            released_next   = 1'b1;
                            task_index_next = pend_idx_reg;
                            kicked_next     = 1'b1;
                            accepted_next   = 1'b1;
                        end
                        pend_valid_next = 1'b1;
                        pend_idx_next   = scan_ext[ptrs_pkg::SLOT_W-1:0];
                        rcnt_next       = rcnt_reg + RCNT_W'(1);
                    end
                end
                if (scan_idx_reg == LAST_IDX)
                begin
                    state_next = ST_FLUSH;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + IDX_W'(1);
                end
            end
            ST_FLUSH:
            begin
                done_next       = 1'b1;
                final_res_next  = 1'b1;
                accepted_next   = 1'b1;
                kicked_next     = kick_now;
                released_next   = pend_valid_reg;
                task_index_next = pend_valid_reg ? pend_idx_reg : '0;
                if (kick_now)
                begin
                    last_kick_next = now_reg;
                end
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            total_reg       <= '0;
            last_kick_reg   <= '0;
            kick_period_reg <= ptrs_pkg::KICK_PERIOD_RST;
            scan_idx_reg    <= '0;
            rcnt_reg        <= '0;
            pend_valid_reg  <= 1'b0;
            any_hit_reg     <= 1'b0;
            done_reg        <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            total_reg      <= total_next;
            last_kick_reg  <= last_kick_next;
            scan_idx_reg   <= scan_idx_next;
            rcnt_reg       <= rcnt_next;
            pend_valid_reg <= pend_valid_next;
            any_hit_reg    <= any_hit_next;
            done_reg       <= done_next;
            if (cfg_we)
            begin
                kick_period_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg        <= now_next;
        pend_idx_reg   <= pend_idx_next;
        released_reg   <= released_next;
        task_index_reg <= task_index_next;
        kicked_reg     <= kicked_next;
        accepted_reg   <= accepted_next;
        final_res_reg  <= final_res_next;
    end

    assign done       = done_reg;
    assign released   = released_reg;
    assign task_index = task_index_reg;
    assign kicked     = kicked_reg;
    assign accepted   = accepted_reg;
    assign final_res  = final_res_reg;

    `ASSERT_IMPLIES(a_release_kicks, clk, rst_n, done_reg && released_reg, kicked_reg)
    `ASSERT_IMPLIES(a_one_token, clk, rst_n, 1'b1, $onehot0(tok_vec))
    `ASSERT_NEXT(a_scan_ends, clk, rst_n, (state_reg == ST_SCAN) && (scan_idx_reg == LAST_IDX), state_reg == ST_FLUSH)
    `ASSERT_NEXT(a_flush_final, clk, rst_n, state_reg == ST_FLUSH, done_reg && final_res_reg && !busy)

endmodule

FILE: src/ptrs_cell.sv
// One task slot: interval, last release time, enable bit and a scan token stage.
`timescale 1ns / 1ps

module ptrs_cell (
    input  logic                      clk,
    input  logic                      rst_n,
    input  ptrs_pkg::cell_cmd_t       cmd,
    input  logic                      sel,
    input  logic                      tok_in,
    output logic                      tok_out,
    output logic                      hit
);

    logic [ptrs_pkg::TIME_W-1:0] interval_reg;
    logic [ptrs_pkg::TIME_W-1:0] last_reg;
    logic [ptrs_pkg::TIME_W-1:0] elapsed;
    logic                        en_reg;
    logic                        tok_reg;

    assign elapsed = cmd.now - last_reg;
    assign hit     = tok_reg & en_reg & (elapsed >= interval_reg);
    assign tok_out = tok_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_reg  <= 1'b0;
            tok_reg <= 1'b0;
        end
        else
        begin
            tok_reg <= tok_in;
            if (cmd.clr_all)
            begin
                en_reg <= 1'b0;
            end
            else if (sel && (cmd.load || cmd.en_set))
            begin
                en_reg <= 1'b1;
            end
            else if (sel && cmd.en_clr)
            begin
                en_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sel && cmd.load)
        begin
            interval_reg <= cmd.period;
            last_reg     <= '0;
        end
        else if (hit)
        begin
            last_reg <= cmd.now;
        end
    end

endmodule

FILE: test/periodic_task_release_scheduler_tb.sv
// Testbench for the periodic task release scheduler with a built-in predictor.
`timescale 1ns / 1ps

module periodic_task_release_scheduler_tb;

    localparam int SLOTS = ptrs_pkg::TASK_SLOTS_DEF;
    localparam int SETTLE_CYCLES = SLOTS + 4;
    localparam logic [ptrs_pkg::FUNC_W-1:0] FN_UNKNOWN_LO = 3'd5;
    localparam logic [ptrs_pkg::FUNC_W-1:0] FN_UNKNOWN_HI = 3'd7;
    localparam logic [ptrs_pkg::TIME_W-1:0] TIME_MAX = 32'hFFFF_FFFF;
    localparam logic [ptrs_pkg::KICK_W-1:0] KICK_MAX = 16'hFFFF;

    typedef struct packed {
        logic                        released;
        logic [ptrs_pkg::SLOT_W-1:0] task_index;
        logic                        kicked;
        logic                        accepted;
        logic                        final_res;
    } sched_result_t;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          start;
    logic                          busy;
    logic [ptrs_pkg::FUNC_W-1:0]   func;
    logic [ptrs_pkg::TIME_W-1:0]   now_ms;
    logic [ptrs_pkg::TIME_W-1:0]   period_ms;
    logic [ptrs_pkg::SLOT_W-1:0]   slot;
    logic                          cfg_we;
    logic [ptrs_pkg::KICK_W-1:0]   cfg_wdata;
    logic                          done;
    logic                          released;
    logic [ptrs_pkg::SLOT_W-1:0]   task_index;
    logic                          kicked;
    logic                          accepted;
    logic                          final_res;

    // Shadow copy of the task table.
    logic [ptrs_pkg::TIME_W-1:0]   interval_q [SLOTS];
    logic [ptrs_pkg::TIME_W-1:0]   last_rel_q [SLOTS];
    logic                          enabled_q  [SLOTS];
    int unsigned                   task_count_q;
    logic [ptrs_pkg::TIME_W-1:0]   last_kick_q;
    logic [ptrs_pkg::KICK_W-1:0]   kick_period_q;

    sched_result_t                 due_results [$];
    logic [ptrs_pkg::TIME_W-1:0]   clock_ms;
    int                            sender_idle_pct;
    int                            mismatches;
    int                            words_sent;
    int                            ticks_sent;
    int                            results_seen;
    int                            releases_seen;

    periodic_task_release_scheduler dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .func       (func),
        .now_ms     (now_ms),
        .period_ms  (period_ms),
        .slot       (slot),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .done       (done),
        .released   (released),
        .task_index (task_index),
        .kicked     (kicked),
        .accepted   (accepted),
        .final_res  (final_res)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    task automatic predict_releases(input logic [ptrs_pkg::FUNC_W-1:0] code,
                                    input logic [ptrs_pkg::TIME_W-1:0] now,
                                    input logic [ptrs_pkg::TIME_W-1:0] period,
                                    input logic [ptrs_pkg::SLOT_W-1:0] sl);
        logic [ptrs_pkg::SLOT_W-1:0] hits [$];
        logic                        kick;
        sched_result_t               r;
        int                          i;
        case (code)
            ptrs_pkg::FN_TICK:
            begin
                kick = (now - last_kick_q) > {16'd0, kick_period_q};
                for (i = 0; i < int'(task_count_q); i++)
                begin
                    if (enabled_q[i] && (now - last_rel_q[i]) >= interval_q[i])
                    begin
                        last_rel_q[i] = now;
                        kick = 1'b1;
                        hits.push_back(ptrs_pkg::SLOT_W'(i));
                    end
                end
                if (kick)
                    last_kick_q = now;
                if (hits.size() == 0)
                    due_results.push_back('{1'b0, '0, kick, 1'b1, 1'b1});
                for (i = 0; i < hits.size(); i++)
                begin
                    r = '{1'b1, hits[i], kick, 1'b1, i == hits.size() - 1};
                    due_results.push_back(r);
                end
            end
            ptrs_pkg::FN_REGISTER:
            begin
                if (task_count_q >= SLOTS)
                begin
                    due_results.push_back('{1'b0, '0, 1'b0, 1'b0, 1'b1});
                end
                else
                begin
                    interval_q[task_count_q] = period;
                    last_rel_q[task_count_q] = '0;
                    enabled_q[task_count_q] = 1'b1;
                    due_results.push_back('{1'b0, ptrs_pkg::SLOT_W'(task_count_q), 1'b0,
                                            1'b1, 1'b1});
                    task_count_q++;
                end
            end
            ptrs_pkg::FN_ENABLE, ptrs_pkg::FN_DISABLE:
            begin
                if (sl < task_count_q)
                    enabled_q[sl] = (code == ptrs_pkg::FN_ENABLE);
                due_results.push_back('{1'b0, sl, 1'b0, 1'b1, 1'b1});
            end
            ptrs_pkg::FN_CLEAR:
            begin
                task_count_q = 0;
                for (i = 0; i < SLOTS; i++)
                    enabled_q[i] = 1'b0;
                last_kick_q = now;
                due_results.push_back('{1'b0, '0, 1'b0, 1'b1, 1'b1});
            end
            default:
                due_results.push_back('{1'b0, '0, 1'b0, 1'b0, 1'b1});
        endcase
    endtask

    task automatic send_word(input logic [ptrs_pkg::FUNC_W-1:0] code,
                             input logic [ptrs_pkg::TIME_W-1:0] now,
                             input logic [ptrs_pkg::TIME_W-1:0] period,
                             input logic [ptrs_pkg::SLOT_W-1:0] sl);
        @(negedge clk);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            start = 1'b0;
            @(negedge clk);
        end
        start = 1'b1;
        func = code;
        now_ms = now;
        period_ms = period;
        slot = sl;
        do
            @(posedge clk);
        while (busy);
        predict_releases(code, now, period, sl);
        words_sent++;
        if (code == ptrs_pkg::FN_TICK)
            ticks_sent++;
    endtask

    task automatic wait_until_idle();
        @(negedge clk);
        start = 1'b0;
        while (due_results.size() != 0 || busy)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_kick_period(input logic [ptrs_pkg::KICK_W-1:0] value);
        wait_until_idle();
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_wdata = value;
        @(negedge clk);
        cfg_we = 1'b0;
        kick_period_q = value;
    endtask

    always @(posedge clk)
    begin : check_results
        sched_result_t got;
        sched_result_t want;
        if (rst_n && done)
        begin
            got = '{released, task_index, kicked, accepted, final_res};
            results_seen++;
            if (got.released)
                releases_seen++;
            if (due_results.size() == 0)
            begin
                report_mismatch("unexpected result", 1, 0);
            end
            else
            begin
                want = due_results.pop_front();
                if (got.released !== want.released)
                    report_mismatch("released", got.released, want.released);
                if (got.task_index !== want.task_index)
                    report_mismatch("task_index", got.task_index, want.task_index);
                if (got.kicked !== want.kicked)
                    report_mismatch("kicked", got.kicked, want.kicked);
                if (got.accepted !== want.accepted)
                    report_mismatch("accepted", got.accepted, want.accepted);
                if (got.final_res !== want.final_res)
                    report_mismatch("final_res", got.final_res, want.final_res);
            end
        end
    end

    task automatic test_empty_table();
        send_word(ptrs_pkg::FN_TICK, '0, TIME_MAX, '0);
        send_word(ptrs_pkg::FN_TICK, 32'd101, '0, 3'd7);
    endtask

    task automatic test_fill_table();
        int i;
        send_word(ptrs_pkg::FN_REGISTER, '0, '0, '0);
        send_word(ptrs_pkg::FN_REGISTER, '0, TIME_MAX, '0);
        for (i = 2; i < SLOTS; i++)
            send_word(ptrs_pkg::FN_REGISTER, '0, 32'(i * 5), '0);
        send_word(ptrs_pkg::FN_REGISTER, '0, 32'd3, '0);
        send_word(ptrs_pkg::FN_DISABLE, '0, '0, 3'd1);
        send_word(ptrs_pkg::FN_TICK, TIME_MAX, '0, '0);
        send_word(ptrs_pkg::FN_ENABLE, '0, '0, 3'd1);
        send_word(ptrs_pkg::FN_TICK, 32'd5, '0, '0);
    endtask

    task automatic test_unknown_codes();
        logic [ptrs_pkg::FUNC_W-1:0] code;
        for (code = FN_UNKNOWN_LO; code != ptrs_pkg::FN_TICK; code++)
            send_word(code, TIME_MAX, TIME_MAX, 3'd7);
    endtask

    task automatic test_clear_table();
        send_word(ptrs_pkg::FN_CLEAR, 32'h8000_0000, '0, '0);
        send_word(ptrs_pkg::FN_ENABLE, '0, '0, 3'd3);
        send_word(ptrs_pkg::FN_DISABLE, '0, '0, 3'd7);
        send_word(ptrs_pkg::FN_TICK, 32'h8000_0064, '0, '0);
        send_word(ptrs_pkg::FN_TICK, 32'h8000_0065, '0, '0);
    endtask

    task automatic test_kick_extremes();
        send_word(ptrs_pkg::FN_CLEAR, 32'h0001_0000, '0, '0);
        write_kick_period('0);
        send_word(ptrs_pkg::FN_TICK, 32'h0001_0000, '0, '0);
        send_word(ptrs_pkg::FN_TICK, 32'h0001_0001, '0, '0);
        write_kick_period(KICK_MAX);
        send_word(ptrs_pkg::FN_TICK, 32'h0002_0000, '0, '0);
        send_word(ptrs_pkg::FN_TICK, 32'h0002_0001, '0, '0);
    endtask

    task automatic run_random_phase(input int count, input int idle_pct);
        int k;
        int pick;
        logic [ptrs_pkg::TIME_W-1:0] period;
        logic [ptrs_pkg::SLOT_W-1:0] sl;
        logic [ptrs_pkg::FUNC_W-1:0] code;
        sender_idle_pct = idle_pct;
        clock_ms = $urandom;
        for (k = 0; k < count; k++)
        begin
            pick = $urandom_range(99);
            sl = ptrs_pkg::SLOT_W'($urandom_range(7));
            if (pick < 45)
            begin
                if (pick < 3)
                    clock_ms = $urandom;
                else
                    clock_ms += $urandom_range(0, 40);
                send_word(ptrs_pkg::FN_TICK, clock_ms, $urandom, sl);
            end
            else if (pick < 65)
            begin
                period = ($urandom_range(7) == 0) ? ptrs_pkg::TIME_W'($urandom)
                                                  : $urandom_range(0, 80);
                send_word(ptrs_pkg::FN_REGISTER, $urandom, period, sl);
            end
            else if (pick < 75)
            begin
                send_word(ptrs_pkg::FN_ENABLE, $urandom, $urandom, sl);
            end
            else if (pick < 85)
            begin
                send_word(ptrs_pkg::FN_DISABLE, $urandom, $urandom, sl);
            end
            else if (pick < 93)
            begin
                send_word(ptrs_pkg::FN_CLEAR, clock_ms, $urandom, sl);
            end
            else
            begin
                code = ptrs_pkg::FUNC_W'($urandom_range(FN_UNKNOWN_LO, FN_UNKNOWN_HI));
                send_word(code, $urandom, $urandom, sl);
            end
        end
    endtask

    task automatic test_random_traffic();
        write_kick_period(ptrs_pkg::KICK_W'($urandom_range(1, 200)));
        run_random_phase(28, 22);
        write_kick_period(ptrs_pkg::KICK_W'($urandom));
        run_random_phase(28, 76);
        write_kick_period(ptrs_pkg::KICK_W'($urandom_range(0, 60)));
        run_random_phase(26, 0);
    endtask

    initial
    begin
        int i;
        rst_n = 1'b0;
        start = 1'b0;
        func = ptrs_pkg::FN_TICK;
        now_ms = '0;
        period_ms = '0;
        slot = '0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        for (i = 0; i < SLOTS; i++)
        begin
            interval_q[i] = '0;
            last_rel_q[i] = '0;
            enabled_q[i] = 1'b0;
        end
        task_count_q = 0;
        last_kick_q = '0;
        kick_period_q = ptrs_pkg::KICK_PERIOD_RST;
        sender_idle_pct = 22;
        mismatches = 0;
        words_sent = 0;
        ticks_sent = 0;
        results_seen = 0;
        releases_seen = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_table();
        test_fill_table();
        test_unknown_codes();
        test_clear_table();
        test_kick_extremes();
        test_random_traffic();
        wait_until_idle();

        $display("Sent %0d words (%0d ticks); checked %0d results with %0d task releases.",
                 words_sent, ticks_sent, results_seen, releases_seen);
        $display("Covered a full table, wrapping time, unknown codes and kick periods 0 to 65535.");
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Run stopped by the time limit with %0d results outstanding.",
                 due_results.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
